### src/bffa_pkg.sv
// bffa_pkg: shared constants for the bitmap first-fit allocator
// field widths, request and status codes, register reset value
// no dependencies

package bffa_pkg;

   localparam int NUM_W    = 14;
   localparam int STATUS_W = 2;
   localparam int WORD_W   = 32;
   localparam int BIT_W    = 5;

   localparam int ENTRIES_DEFAULT = 8192;

   localparam logic [NUM_W-1:0] CFG_RESET = 14'd8192;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_ALREADY_FR = 2'd3;

endpackage

### src/bitmap_first_fit_allocator.sv
// bitmap_first_fit_allocator: one-bit-per-entry allocation map with first-fit search
// map held as 32-bit words in a local memory, scanned one word per cycle
// depends on bffa_pkg
//
//   channel   ports                                   handshake
//   request   req_operation, req_entry_number         start, busy (taken when start & !busy)
//   response  rsp_allocated_number, rsp_status,       rsp_valid, one cycle, no back-pressure
//             rsp_free_count
//   csr       csr_write_data                          csr_write_enable, no wait
//
// a free reads the addressed map word and gives its response strobe from the free state;
// an allocate reads the map one word at a time from word 0 up to the word that holds the
// granted entry, or up to the last word below the limit when the map is full.
// the next request may be started in the cycle of the strobe.
// after reset a clearing pass writes the map, one word a cycle, all ceil(ENTRIES / 32)
// words, with busy high; csr writes are taken meanwhile.

module bitmap_first_fit_allocator #(
   parameter int ENTRIES = bffa_pkg::ENTRIES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_operation,
   input  logic [bffa_pkg::NUM_W-1:0]    req_entry_number,
   output logic                          rsp_valid,
   output logic [bffa_pkg::NUM_W-1:0]    rsp_allocated_number,
   output logic [bffa_pkg::STATUS_W-1:0] rsp_status,
   output logic [bffa_pkg::NUM_W-1:0]    rsp_free_count,
   input  logic                          csr_write_enable,
   input  logic [bffa_pkg::NUM_W-1:0]    csr_write_data
);

   localparam int NW      = bffa_pkg::NUM_W;
   localparam int BW      = bffa_pkg::BIT_W;
   localparam int WW      = bffa_pkg::WORD_W;
   localparam int WORDS   = (ENTRIES + WW - 1) / WW;
   localparam int WAW     = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int IW      = (NW > WAW + BW) ? NW : WAW + BW;
   localparam int NUM_MAX = (1 << NW) - 1;
   localparam int LIM_CAP = (ENTRIES > NUM_MAX) ? NUM_MAX : ENTRIES;

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_ALLOC = 4'b0100,
      S_FREE  = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [NW-1:0]        limit_reg_ff;
   logic [NW-1:0]        used_ff, used_in;
   logic [WAW-1:0]       word_ff, word_in;
   logic [BW-1:0]        bit_ff, bit_in;
   logic                 range_err_ff, range_err_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [NW-1:0]        rsp_num_ff, rsp_num_in;
   logic [bffa_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [NW-1:0]        rsp_free_ff, rsp_free_in;

   logic [WW-1:0]        map_mem [WORDS];
   logic [WW-1:0]        rd_data_ff;
   logic [WAW-1:0]       rd_addr;
   logic                 wr_en;
   logic [WAW-1:0]       wr_addr;
   logic [WW-1:0]        wr_data;

   logic [NW-1:0]        limit;
   logic [IW-1:0]        limit_m1;
   logic [WAW-1:0]       last_word;
   logic [BW-1:0]        last_bit;
   logic [IW-1:0]        req_idx;
   logic [WW-1:0]        elig_mask;
   logic [WW-1:0]        cand;
   logic                 found;
   logic [BW-1:0]        found_bit;
   logic [IW-1:0]        grant_wide;

   // active limit is the smaller of the register and the map size
   always_comb begin
      if (limit_reg_ff > NW'(LIM_CAP)) begin
         limit = NW'(LIM_CAP);
      end else begin
         limit = limit_reg_ff;
      end
   end

   assign limit_m1  = IW'(limit) - IW'(1);
   assign last_word = limit_m1[WAW+BW-1:BW];
   assign last_bit  = limit_m1[BW-1:0];
   assign req_idx   = IW'(req_entry_number) - IW'(1);

   // bits of the last word at or above the limit are never granted
   always_comb begin
      for (int b = 0; b < WW; b++) begin
         elig_mask[b] = (word_ff != last_word) || (BW'(b) <= last_bit);
      end
   end

   assign cand = ~rd_data_ff & elig_mask;

   always_comb begin
      found     = 1'b0;
      found_bit = '0;
      for (int b = WW - 1; b >= 0; b--) begin
         if (cand[b]) begin
            found     = 1'b1;
            found_bit = BW'(b);
         end
      end
   end

   assign grant_wide = IW'({word_ff, found_bit}) + IW'(1);

   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      word_in       = word_ff;
      bit_in        = bit_ff;
      range_err_in  = range_err_ff;
      rsp_valid_in  = 1'b0;
      rsp_num_in    = rsp_num_ff;
      rsp_status_in = rsp_status_ff;
      rsp_free_in   = rsp_free_ff;
      rd_addr       = word_ff;
      wr_en         = 1'b0;
      wr_addr       = word_ff;
      wr_data       = rd_data_ff;

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '0;
            word_in = word_ff + WAW'(1);
            if (word_ff == WAW'(WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_operation == bffa_pkg::OP_ALLOC) begin
               rd_addr = '0;
            end else begin
               rd_addr = req_idx[WAW+BW-1:BW];
            end
            if (start) begin
               range_err_in = (req_entry_number == '0) || (req_entry_number > limit);
               if (req_operation == bffa_pkg::OP_ALLOC) begin
                  word_in  = '0;
                  state_in = S_ALLOC;
               end else begin
                  word_in  = req_idx[WAW+BW-1:BW];
                  bit_in   = req_idx[BW-1:0];
                  state_in = S_FREE;
               end
            end
         end
         S_ALLOC: begin
            rd_addr = word_ff + WAW'(1);
            if (limit != '0 && found) begin
               wr_en         = 1'b1;
               wr_data       = rd_data_ff | (WW'(1) << found_bit);
               used_in       = used_ff + NW'(1);
               rsp_valid_in  = 1'b1;
               rsp_num_in    = grant_wide[NW-1:0];
               rsp_status_in = bffa_pkg::ST_OK;
               state_in      = S_IDLE;
            end else if (limit == '0 || word_ff == last_word) begin
               rsp_valid_in  = 1'b1;
               rsp_num_in    = '0;
               rsp_status_in = bffa_pkg::ST_FULL;
               state_in      = S_IDLE;
            end else begin
               word_in = word_ff + WAW'(1);
            end
         end
         S_FREE: begin
            rsp_valid_in = 1'b1;
            rsp_num_in   = '0;
            state_in     = S_IDLE;
            if (range_err_ff) begin
               rsp_status_in = bffa_pkg::ST_RANGE;
            end else if (!rd_data_ff[bit_ff]) begin
               rsp_status_in = bffa_pkg::ST_ALREADY_FR;
            end else begin
               wr_en         = 1'b1;
               wr_data       = rd_data_ff & ~(WW'(1) << bit_ff);
               rsp_status_in = bffa_pkg::ST_OK;
               if (used_ff != '0) begin
                  used_in = used_ff - NW'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // free count from the count as it stands after this request
      if (limit > used_in) begin
         rsp_free_in = limit - used_in;
      end else begin
         rsp_free_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= map_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         used_ff      <= '0;
         word_ff      <= '0;
         limit_reg_ff <= bffa_pkg::CFG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         word_ff      <= word_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            limit_reg_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      bit_ff        <= bit_in;
      range_err_ff  <= range_err_in;
      rsp_num_ff    <= rsp_num_in;
      rsp_status_ff <= rsp_status_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign busy                 = (state_ff != S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_allocated_number = rsp_num_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_free_count       = rsp_free_ff;

endmodule
